// File: hdl/approx_median_background_subtract_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the approximate median background subtractor
// Shared concurrent assertion forms used by the top-level RTL file of the block.
// ----------------------------------------------------------------------------
`ifndef APPROX_MEDIAN_BACKGROUND_SUBTRACT_DEFINES_SVH
`define APPROX_MEDIAN_BACKGROUND_SUBTRACT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define AMBS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define AMBS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ambs_pkg.sv
// ----------------------------------------------------------------------------
// ambs_pkg
// Types, codes and constants shared by the background subtractor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ambs_pkg;

  localparam int unsigned CH_W        = 8;
  localparam int unsigned NUM_CH      = 3;
  localparam int unsigned FRAME_W     = 31;
  localparam int unsigned LEARN_W     = 16;
  localparam int unsigned ROW_W       = 9;
  localparam int unsigned COL_W       = 10;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned PADDR_W     = 4;

  localparam int unsigned DEF_MAX_ROWS    = 512;
  localparam int unsigned DEF_MAX_COLUMNS = 1024;

  // Remainder pipeline: REM_DIGITS quotient bits per stage.
  localparam int unsigned REM_DIGITS = 4;
  localparam int unsigned REM_STAGES = (FRAME_W + REM_DIGITS - 1) / REM_DIGITS;
  localparam int unsigned REM_W      = REM_STAGES * REM_DIGITS;

  localparam logic [MODE_W-1:0] MODE_LOAD     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SUBTRACT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UPDATE   = 2'd2;

  localparam logic [CH_W-1:0]    RST_LOW_LIMIT       = 8'd40;
  localparam logic [CH_W-1:0]    RST_HIGH_LIMIT      = 8'd80;
  localparam logic [CH_W-1:0]    RST_SAMPLING_PERIOD = 8'd7;
  localparam logic [LEARN_W-1:0] RST_LEARNING_LENGTH = 16'd30;

  typedef enum logic [1:0] {
    REG_LOW_LIMIT       = 2'd0,
    REG_HIGH_LIMIT      = 2'd1,
    REG_SAMPLING_PERIOD = 2'd2,
    REG_LEARNING_LENGTH = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CH_W-1:0]    low_limit;
    logic [CH_W-1:0]    high_limit;
    logic [CH_W-1:0]    sampling_period;
    logic [LEARN_W-1:0] learning_length;
  } cfg_t;

  typedef struct packed {
    logic            low_over;
    logic            high_over;
    logic [CH_W-1:0] stepped;
  } lane_res_t;

endpackage

`default_nettype wire

// File: hdl/ambs_regs.sv
// ----------------------------------------------------------------------------
// ambs_regs
// APB register file holding the thresholds, sampling period and learning length.
// ----------------------------------------------------------------------------
`default_nettype none

module ambs_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ambs_pkg::PADDR_W-1:0]       paddr,
  input  logic [ambs_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ambs_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  output ambs_pkg::cfg_t                     cfg
);
  import ambs_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_limit       <= RST_LOW_LIMIT;
      cfg.high_limit      <= RST_HIGH_LIMIT;
      cfg.sampling_period <= RST_SAMPLING_PERIOD;
      cfg.learning_length <= RST_LEARNING_LENGTH;
    end else if (wr_en) begin
      unique case (idx)
        REG_LOW_LIMIT:       cfg.low_limit       <= pwdata[CH_W-1:0];
        REG_HIGH_LIMIT:      cfg.high_limit      <= pwdata[CH_W-1:0];
        REG_SAMPLING_PERIOD: cfg.sampling_period <= pwdata[CH_W-1:0];
        REG_LEARNING_LENGTH: cfg.learning_length <= pwdata[LEARN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LOW_LIMIT:       prdata = APB_DATA_W'(cfg.low_limit);
      REG_HIGH_LIMIT:      prdata = APB_DATA_W'(cfg.high_limit);
      REG_SAMPLING_PERIOD: prdata = APB_DATA_W'(cfg.sampling_period);
      REG_LEARNING_LENGTH: prdata = APB_DATA_W'(cfg.learning_length);
      default:             prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/ambs_rem.sv
// ----------------------------------------------------------------------------
// ambs_rem
// Pipelined restoring remainder of the frame number by the sampling period.
// ----------------------------------------------------------------------------
`default_nettype none

module ambs_rem (
  input  logic                            clk,
  input  logic                            en,
  input  logic [ambs_pkg::FRAME_W-1:0]    dividend,
  input  logic [ambs_pkg::CH_W-1:0]       divisor,
  output logic [ambs_pkg::CH_W-1:0]       remainder
);
  import ambs_pkg::*;

  logic [REM_W-1:0] num       [REM_STAGES];
  logic [CH_W-1:0]  part      [REM_STAGES];
  logic [REM_W-1:0] num_next  [REM_STAGES];
  logic [CH_W-1:0]  part_next [REM_STAGES];

  function automatic logic [CH_W-1:0] rem_step(input logic [CH_W-1:0]       r,
                                               input logic [REM_DIGITS-1:0] bits,
                                               input logic [CH_W-1:0]       d);
    logic [CH_W:0]   t;
    logic [CH_W-1:0] acc;
    acc = r;
    for (int i = REM_DIGITS - 1; i >= 0; i--) begin
      t = {acc, bits[i]};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
      end
      acc = t[CH_W-1:0];
    end
    return acc;
  endfunction

  always_comb begin
    logic [REM_W-1:0] n;
    logic [CH_W-1:0]  r;
    for (int k = 0; k < REM_STAGES; k++) begin
      n = (k == 0) ? REM_W'(dividend) : num[(k == 0) ? 0 : k - 1];
      r = (k == 0) ? '0 : part[(k == 0) ? 0 : k - 1];
      part_next[k] = rem_step(r, n[REM_W-1 -: REM_DIGITS], divisor);
      num_next[k]  = n << REM_DIGITS;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < REM_STAGES; k++) begin
        num[k]  <= num_next[k];
        part[k] <= part_next[k];
      end
    end
  end

  assign remainder = part[REM_STAGES-1];

endmodule

`default_nettype wire

// File: hdl/ambs_lane.sv
// ----------------------------------------------------------------------------
// ambs_lane
// One colour channel: difference against both limits and a unit step toward
// the pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module ambs_lane (
  input  logic [ambs_pkg::CH_W-1:0] pix,
  input  logic [ambs_pkg::CH_W-1:0] model,
  input  logic [ambs_pkg::CH_W-1:0] low_limit,
  input  logic [ambs_pkg::CH_W-1:0] high_limit,
  output ambs_pkg::lane_res_t       res
);
  import ambs_pkg::*;

  logic            pix_above;
  logic            pix_below;
  logic [CH_W-1:0] diff;

  assign pix_above = pix > model;
  assign pix_below = pix < model;
  assign diff      = pix_above ? (pix - model) : (model - pix);

  always_comb begin
    res.low_over  = diff > low_limit;
    res.high_over = diff > high_limit;
    if (pix_above) begin
      res.stepped = model + 8'd1;
    end else if (pix_below) begin
      res.stepped = model - 8'd1;
    end else begin
      res.stepped = model;
    end
  end

endmodule

`default_nettype wire

// File: hdl/approx_median_background_subtract.sv
// ----------------------------------------------------------------------------
// approx_median_background_subtract
// Per-pixel RGB background model with load, subtract and unit-step update.
// ----------------------------------------------------------------------------
// The block takes one pixel beat per clock while pixel_stall is low and
// returns a result beat for subtract pixels only; load and update pixels give
// no result. Pixels move in step with the eight-stage remainder pipeline that
// works out the frame number modulo the sampling period; the model memory is
// read one stage before the end and written at the last stage, and the last
// write is forwarded so that back-to-back pixels at one position see each
// other's updates. After reset the block clears the model memory one entry per
// clock, all MAX_ROWS times MAX_COLUMNS entries (524288 at the default size), and
// stalls pixels during that pass; register writes are taken throughout.
`default_nettype none
`include "approx_median_background_subtract_defines.svh"

module approx_median_background_subtract #(
  parameter int unsigned MAX_ROWS    = ambs_pkg::DEF_MAX_ROWS,
  parameter int unsigned MAX_COLUMNS = ambs_pkg::DEF_MAX_COLUMNS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ambs_pkg::PADDR_W-1:0]    paddr,
  input  logic [ambs_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ambs_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  input  logic                            pixel_valid,
  output logic                            pixel_stall,
  input  logic [ambs_pkg::MODE_W-1:0]     mode,
  input  logic [ambs_pkg::ROW_W-1:0]      row,
  input  logic [ambs_pkg::COL_W-1:0]      column,
  input  logic [ambs_pkg::CH_W-1:0]       red,
  input  logic [ambs_pkg::CH_W-1:0]       green,
  input  logic [ambs_pkg::CH_W-1:0]       blue,
  input  logic [ambs_pkg::FRAME_W-1:0]    frame_number,
  input  logic                            update_background,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic                            low_foreground,
  output logic                            high_foreground
);
  import ambs_pkg::*;

  localparam int unsigned DEPTH  = MAX_ROWS * MAX_COLUMNS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NST    = REM_STAGES;
  localparam int unsigned X      = NST - 1;
  localparam logic [12:0]       ROWS_LIM  = 13'(MAX_ROWS);
  localparam logic [12:0]       COLS_LIM  = 13'(MAX_COLUMNS);
  localparam logic [23:0]       COLS_MUL  = 24'(MAX_COLUMNS);
  localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(DEPTH - 1);

  typedef logic [NUM_CH-1:0][CH_W-1:0] word_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    word_t             pix;
    logic              mask;
    logic              learn;
    logic              inr;
    logic [ADDR_W-1:0] addr;
  } item_t;

  cfg_t            cfg;
  item_t           item_in;
  item_t           p [NST];
  logic [NST-1:0]  pv;
  logic [23:0]     addr_full;
  logic [CH_W-1:0] rem;
  logic            adv;
  logic            accept;
  logic            clearing;
  logic [ADDR_W-1:0] clr_addr;
  word_t           mem [DEPTH];
  word_t           rd_q;
  logic            wr_en;
  logic [ADDR_W-1:0] wr_addr;
  word_t           wr_data;
  logic            mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  word_t           mem_wdata;
  word_t           model_word;
  lane_res_t       lane_res [NUM_CH];
  word_t           stepped;
  logic            low_any;
  logic            high_any;
  logic            do_update;
  logic            x_res;
  logic            x_we;
  word_t           x_data;

  ambs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ambs_rem u_rem (
    .clk       (clk),
    .en        (adv),
    .dividend  (frame_number),
    .divisor   (cfg.sampling_period),
    .remainder (rem)
  );

  assign x_res       = pv[X] && (p[X].mode == MODE_SUBTRACT);
  assign adv         = !(result_valid && result_stall && x_res);
  assign pixel_stall = !adv || clearing;
  assign accept      = pixel_valid && !pixel_stall;

  assign addr_full = 24'(row) * COLS_MUL + 24'(column);

  always_comb begin
    item_in.mode   = mode;
    item_in.pix[0] = red;
    item_in.pix[1] = green;
    item_in.pix[2] = blue;
    item_in.mask   = update_background;
    item_in.learn  = frame_number < FRAME_W'(cfg.learning_length);
    item_in.inr    = ({4'b0, row} < ROWS_LIM) && ({3'b0, column} < COLS_LIM);
    item_in.addr   = addr_full[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else if (adv) begin
      pv <= {pv[NST-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p[0] <= item_in;
      for (int k = 1; k < NST; k++) begin
        p[k] <= p[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == CLR_LAST) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
    end
  end

  always_comb begin
    if (!p[X].inr) begin
      model_word = '0;
    end else if (wr_en && (wr_addr == p[X].addr)) begin
      model_word = wr_data;
    end else begin
      model_word = rd_q;
    end
  end

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
    ambs_lane u_lane (
      .pix        (p[X].pix[ch]),
      .model      (model_word[ch]),
      .low_limit  (cfg.low_limit),
      .high_limit (cfg.high_limit),
      .res        (lane_res[ch])
    );
  end

  always_comb begin
    low_any  = 1'b0;
    high_any = 1'b0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      low_any     = low_any | lane_res[ch].low_over;
      high_any    = high_any | lane_res[ch].high_over;
      stepped[ch] = lane_res[ch].stepped;
    end
  end

  assign do_update = (cfg.sampling_period != '0) && (rem == 8'd1)
                     && (p[X].mask || p[X].learn);
  assign x_we      = pv[X] && p[X].inr
                     && ((p[X].mode == MODE_LOAD)
                         || ((p[X].mode == MODE_UPDATE) && do_update));
  assign x_data    = (p[X].mode == MODE_LOAD) ? p[X].pix : stepped;

  assign mem_we    = clearing || (adv && x_we);
  assign mem_waddr = clearing ? clr_addr : p[X].addr;
  assign mem_wdata = clearing ? '0 : x_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (adv) begin
      rd_q <= mem[p[X-1].addr];
    end
  end

  // The write leaving the last stage is not yet visible to the read issued at
  // the same edge, so it is registered and forwarded.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_en <= 1'b0;
    end else if (adv) begin
      wr_en <= x_we;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wr_addr <= p[X].addr;
      wr_data <= x_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv && x_res) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && x_res) begin
      low_foreground  <= low_any;
      high_foreground <= high_any;
    end
  end

  `AMBS_ASSERT_IMP(a_no_pixel_write_in_clear, clk, rst, clearing, !(adv && x_we), "pixel write during clear pass")
  `AMBS_ASSERT_IMP(a_write_legal, clk, rst, adv && x_we, p[X].inr && (p[X].mode == MODE_LOAD || p[X].mode == MODE_UPDATE), "model write from a pixel that must not write")
  `AMBS_ASSERT_NXT(a_clear_once, clk, rst, !clearing, !clearing, "clear pass restarted without reset")
  `AMBS_ASSERT_NXT(a_result_loaded, clk, rst, adv && x_res, result_valid, "subtract pixel produced no result beat")

endmodule

`default_nettype wire

// File: tb/sv/approx_median_background_subtract_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// approx_median_background_subtract_tb
// Self-checking bench for the per-pixel background subtractor. A shadow copy
// of the background store and of the four registers predicts the two
// foreground flags of every subtract beat, while load and update beats only
// change the shadow store and unused-mode beats change nothing. A directed
// part covers threshold edges, the update gating rules and back-to-back beats
// on one position. Random phases run under several register settings, zero
// and full scale, with random result stalls and, in most, random pixel gaps.
// ----------------------------------------------------------------------------
module approx_median_background_subtract_tb;
  import ambs_pkg::*;

  localparam int unsigned N_ROWS         = DEF_MAX_ROWS;
  localparam int unsigned N_COLS         = DEF_MAX_COLUMNS;
  localparam int unsigned CLEAR_CYCLES   = N_ROWS * N_COLS;
  localparam int unsigned WATCHDOG_LIMIT = 4 * CLEAR_CYCLES + 4096;
  localparam int unsigned LATENCY_GUARD  = 16;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef logic [NUM_CH-1:0][CH_W-1:0] rgb_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   column;
    rgb_t               color;
    logic [FRAME_W-1:0] frame;
    logic               mask_bg;
  } pixel_t;

  typedef struct packed {
    logic low_fg;
    logic high_fg;
  } fg_flags_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_W-1:0]    paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  pixel_valid = 1'b0;
  logic                  pixel_stall;
  logic [MODE_W-1:0]     mode = MODE_LOAD;
  logic [ROW_W-1:0]      row = '0;
  logic [COL_W-1:0]      column = '0;
  logic [CH_W-1:0]       red = '0;
  logic [CH_W-1:0]       green = '0;
  logic [CH_W-1:0]       blue = '0;
  logic [FRAME_W-1:0]    frame_number = '0;
  logic                  update_background = 1'b0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic                  low_foreground;
  logic                  high_foreground;

  cfg_t        shadow_cfg;
  rgb_t        shadow_store [int unsigned];
  fg_flags_t   fg_flags_due [$];
  fg_flags_t   due_flags;
  logic [ROW_W-1:0] hot_row [8];
  logic [COL_W-1:0] hot_col [8];

  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned results_checked = 0;
  int unsigned mode_count [4] = '{default: 0};
  int unsigned reg_writes = 0;
  int unsigned settings_run = 0;
  int unsigned rx_hold_left = 0;
  int unsigned rx_roll;
  bit          tx_gaps_on = 1'b1;

  approx_median_background_subtract dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .mode(mode),
    .row(row),
    .column(column),
    .red(red),
    .green(green),
    .blue(blue),
    .frame_number(frame_number),
    .update_background(update_background),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .low_foreground(low_foreground),
    .high_foreground(high_foreground)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ERROR %s: got %0h, expected %0h", $time, what, got, want);
    error_count++;
  endtask

  function automatic rgb_t stored_color(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
    int unsigned key;
    key = r * N_COLS + c;
    if (r < N_ROWS && c < N_COLS && shadow_store.exists(key)) begin
      return shadow_store[key];
    end
    return '0;
  endfunction

  function automatic void apply_pixel_to_model(input pixel_t p);
    rgb_t            stored;
    int unsigned     key;
    bit              on_grid;
    fg_flags_t       flags;
    logic [CH_W-1:0] diff;
    on_grid = (p.row < N_ROWS) && (p.column < N_COLS);
    key = p.row * N_COLS + p.column;
    stored = stored_color(p.row, p.column);
    mode_count[p.mode]++;
    case (p.mode)
      MODE_LOAD: begin
        if (on_grid) shadow_store[key] = p.color;
      end
      MODE_SUBTRACT: begin
        flags = '0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
          diff = (p.color[ch] > stored[ch]) ? p.color[ch] - stored[ch]
                                            : stored[ch] - p.color[ch];
          if (diff > shadow_cfg.low_limit) flags.low_fg = 1'b1;
          if (diff > shadow_cfg.high_limit) flags.high_fg = 1'b1;
        end
        fg_flags_due.push_back(flags);
      end
      MODE_UPDATE: begin
        if (on_grid && shadow_cfg.sampling_period != 0 &&
            (p.frame % shadow_cfg.sampling_period) == 1 &&
            (p.mask_bg || p.frame < shadow_cfg.learning_length)) begin
          for (int ch = 0; ch < NUM_CH; ch++) begin
            if (p.color[ch] > stored[ch]) stored[ch] = stored[ch] + CH_W'(1);
            else if (p.color[ch] < stored[ch]) stored[ch] = stored[ch] - CH_W'(1);
          end
          shadow_store[key] = stored;
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [APB_DATA_W-1:0] shadow_register(input reg_idx_t idx);
    case (idx)
      REG_LOW_LIMIT:       return APB_DATA_W'(shadow_cfg.low_limit);
      REG_HIGH_LIMIT:      return APB_DATA_W'(shadow_cfg.high_limit);
      REG_SAMPLING_PERIOD: return APB_DATA_W'(shadow_cfg.sampling_period);
      default:             return APB_DATA_W'(shadow_cfg.learning_length);
    endcase
  endfunction

  // Leaves psel high so that transfers can follow back to back.
  task automatic apb_access(input bit is_write, input reg_idx_t idx,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (is_write) begin
      reg_writes++;
      case (idx)
        REG_LOW_LIMIT:       shadow_cfg.low_limit = wdata[CH_W-1:0];
        REG_HIGH_LIMIT:      shadow_cfg.high_limit = wdata[CH_W-1:0];
        REG_SAMPLING_PERIOD: shadow_cfg.sampling_period = wdata[CH_W-1:0];
        default:             shadow_cfg.learning_length = wdata[LEARN_W-1:0];
      endcase
    end
  endtask

  task automatic apb_release();
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_settings(input logic [CH_W-1:0] low, input logic [CH_W-1:0] high,
                                input logic [CH_W-1:0] period,
                                input logic [LEARN_W-1:0] learn);
    logic [APB_DATA_W-1:0] unused_rd;
    apb_access(1'b1, REG_LOW_LIMIT, APB_DATA_W'(low), unused_rd);
    apb_access(1'b1, REG_HIGH_LIMIT, APB_DATA_W'(high), unused_rd);
    apb_access(1'b1, REG_SAMPLING_PERIOD, APB_DATA_W'(period), unused_rd);
    apb_access(1'b1, REG_LEARNING_LENGTH, APB_DATA_W'(learn), unused_rd);
    apb_release();
    settings_run++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_pixel(input pixel_t p);
    int unsigned gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    mode <= p.mode;
    row <= p.row;
    column <= p.column;
    red <= p.color[0];
    green <= p.color[1];
    blue <= p.color[2];
    frame_number <= p.frame;
    update_background <= p.mask_bg;
    do @(posedge clk); while (pixel_stall);
    apply_pixel_to_model(p);
  endtask

  task automatic send_fields(input logic [MODE_W-1:0] m, input logic [ROW_W-1:0] r,
                             input logic [COL_W-1:0] c, input logic [CH_W-1:0] red_v,
                             input logic [CH_W-1:0] green_v, input logic [CH_W-1:0] blue_v,
                             input logic [FRAME_W-1:0] f, input logic bg);
    pixel_t p;
    p.mode = m;
    p.row = r;
    p.column = c;
    p.color = {blue_v, green_v, red_v};
    p.frame = f;
    p.mask_bg = bg;
    send_pixel(p);
  endtask

  task automatic drain_results(input int unsigned extra);
    pixel_valid <= 1'b0;
    do @(posedge clk); while (fg_flags_due.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  function automatic logic [CH_W-1:0] offset_channel(input logic [CH_W-1:0] base,
                                                     input int diff);
    int v;
    v = $urandom_range(0, 1) ? int'(base) + diff : int'(base) - diff;
    if (v < 0) v = 0;
    else if (v > 255) v = 255;
    return v[CH_W-1:0];
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t      p;
    int unsigned pick;
    int unsigned slot;
    int unsigned edge_ch;
    int          k;
    rgb_t        stored;
    pick = $urandom_range(0, 99);
    if (pick < 15) p.mode = MODE_LOAD;
    else if (pick < 55) p.mode = MODE_SUBTRACT;
    else if (pick < 95) p.mode = MODE_UPDATE;
    else p.mode = MODE_UNUSED;
    if ($urandom_range(0, 99) < 85) begin
      slot = $urandom_range(0, 7);
      p.row = hot_row[slot];
      p.column = hot_col[slot];
    end else begin
      p.row = ROW_W'($urandom_range(0, (1 << ROW_W) - 1));
      p.column = COL_W'($urandom_range(0, (1 << COL_W) - 1));
    end
    stored = stored_color(p.row, p.column);
    pick = $urandom_range(0, 4);
    edge_ch = $urandom_range(0, NUM_CH - 1);
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (p.mode == MODE_SUBTRACT && pick == 0) begin
        p.color[ch] = offset_channel(stored[ch], (ch == edge_ch)
          ? int'(shadow_cfg.low_limit) + int'($urandom_range(0, 1))
          : int'($urandom_range(0, shadow_cfg.low_limit)));
      end else if (p.mode == MODE_SUBTRACT && pick == 1) begin
        p.color[ch] = offset_channel(stored[ch], (ch == edge_ch)
          ? int'(shadow_cfg.high_limit) + int'($urandom_range(0, 1))
          : int'($urandom_range(0, shadow_cfg.high_limit)));
      end else if (pick == 2) begin
        p.color[ch] = offset_channel(stored[ch], int'($urandom_range(0, 3)));
      end else if (pick == 3) begin
        p.color[ch] = $urandom_range(0, 1) ? '1 : '0;
      end else begin
        p.color[ch] = CH_W'($urandom_range(0, 255));
      end
    end
    case ($urandom_range(0, 3))
      0: k = $urandom_range(0, 40);
      1: k = $urandom_range(0, (1 << 23) - 1);
      2: begin
        k = -1;
        if (shadow_cfg.sampling_period != 0) begin
          k = int'(shadow_cfg.learning_length / shadow_cfg.sampling_period) +
              int'($urandom_range(0, 2)) - 1;
        end
      end
      default: k = -1;
    endcase
    if (k < 0 || shadow_cfg.sampling_period == 0) begin
      p.frame = FRAME_W'($urandom);
    end else begin
      p.frame = FRAME_W'(k * int'(shadow_cfg.sampling_period) + 1);
    end
    p.mask_bg = 1'($urandom_range(0, 1));
    return p;
  endfunction

  // Reads every register against the shadow copy, once at reset values and
  // once after random writes whose upper bits must be dropped.
  task automatic test_register_access();
    logic [APB_DATA_W-1:0] got;
    for (int pass = 0; pass < 2; pass++) begin
      for (int i = 0; i < 4; i++) begin
        apb_access(1'b0, reg_idx_t'(i), '0, got);
        if (got !== shadow_register(reg_idx_t'(i))) begin
          report_mismatch("register read", got, shadow_register(reg_idx_t'(i)));
        end
      end
      if (pass == 0) begin
        for (int i = 0; i < 4; i++) begin
          apb_access(1'b1, reg_idx_t'(i), $urandom, got);
        end
      end
    end
    apb_release();
  endtask

  task automatic test_directed();
    drain_results(LATENCY_GUARD);
    write_settings(8'd10, 8'd20, 8'd4, 16'd100);
    tx_gaps_on = 1'b0;
    send_fields(MODE_SUBTRACT, 511, 1023, 0, 0, 0, 0, 0);
    send_fields(MODE_LOAD, 0, 0, 100, 100, 100, 0, 0);
    send_fields(MODE_LOAD, 511, 1023, 255, 255, 255, 0, 0);
    send_fields(MODE_SUBTRACT, 0, 0, 110, 100, 100, 0, 0);
    send_fields(MODE_SUBTRACT, 0, 0, 100, 89, 100, 0, 0);
    send_fields(MODE_SUBTRACT, 0, 0, 100, 100, 120, 0, 0);
    send_fields(MODE_SUBTRACT, 0, 0, 79, 100, 100, 0, 0);
    send_fields(MODE_SUBTRACT, 511, 1023, 0, 0, 0, 0, 0);
    send_fields(MODE_SUBTRACT, 511, 1023, 255, 255, 255, 0, 0);
    send_fields(MODE_UNUSED, 0, 0, 0, 0, 0, 1, 1);
    send_fields(MODE_SUBTRACT, 0, 0, 100, 100, 100, 0, 0);
    send_fields(MODE_UPDATE, 0, 0, 200, 0, 100, 5, 0);
    send_fields(MODE_SUBTRACT, 0, 0, 111, 89, 110, 0, 0);
    send_fields(MODE_UPDATE, 0, 0, 255, 255, 255, 6, 1);
    send_fields(MODE_UPDATE, 0, 0, 255, 0, 100, 101, 0);
    send_fields(MODE_UPDATE, 0, 0, 255, 0, 100, 101, 1);
    send_fields(MODE_UPDATE, 0, 0, 255, 0, 100, 31'h7FFF_FFFD, 1);
    send_fields(MODE_SUBTRACT, 0, 0, 113, 87, 90, 0, 0);
    send_fields(MODE_LOAD, 3, 5, 0, 0, 255, 0, 0);
    send_fields(MODE_UPDATE, 3, 5, 0, 255, 255, 1, 1);
    send_fields(MODE_SUBTRACT, 3, 5, 11, 1, 255, 0, 0);
    send_fields(MODE_LOAD, 511, 1023, 0, 0, 0, 0, 0);
    send_fields(MODE_SUBTRACT, 511, 1023, 255, 0, 0, 0, 0);
    send_fields(MODE_UPDATE, 511, 1023, 255, 255, 255, 1, 0);
    send_fields(MODE_SUBTRACT, 511, 1023, 0, 0, 0, 0, 0);
  endtask

  task automatic test_random_settings(input logic [CH_W-1:0] low,
                                      input logic [CH_W-1:0] high,
                                      input logic [CH_W-1:0] period,
                                      input logic [LEARN_W-1:0] learn,
                                      input int unsigned count, input bit gaps,
                                      input bit pause_midway);
    drain_results(LATENCY_GUARD);
    write_settings(low, high, period, learn);
    tx_gaps_on = gaps;
    for (int i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2) drain_results(0);
      send_pixel(random_pixel());
    end
  endtask

  always @(posedge clk) begin
    if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 45) begin
        result_stall <= 1'b0;
        rx_hold_left <= $urandom_range(0, 24);
      end else if (rx_roll < 92) begin
        result_stall <= 1'b1;
        rx_hold_left <= $urandom_range(0, 2);
      end else begin
        result_stall <= 1'b1;
        rx_hold_left <= $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (fg_flags_due.size() == 0) begin
        report_mismatch("result beat with no subtract pixel pending", 0, 0);
      end else begin
        due_flags = fg_flags_due.pop_front();
        results_checked++;
        if (low_foreground !== due_flags.low_fg) begin
          report_mismatch("low_foreground", 32'(low_foreground), 32'(due_flags.low_fg));
        end
        if (high_foreground !== due_flags.high_fg) begin
          report_mismatch("high_foreground", 32'(high_foreground), 32'(due_flags.high_fg));
        end
      end
    end
  end

  // The clearing pass after reset holds off pixels for a whole store sweep,
  // so the limit is set well above that.
  always @(posedge clk) begin
    if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ERROR watchdog: no beat for %0d cycles", $time, idle_cycles);
      $display("** approx_median_background_subtract: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    shadow_cfg = '{RST_LOW_LIMIT, RST_HIGH_LIMIT, RST_SAMPLING_PERIOD, RST_LEARNING_LENGTH};
    hot_row[0] = '0;
    hot_col[0] = '0;
    hot_row[1] = '1;
    hot_col[1] = '1;
    for (int i = 2; i < 8; i++) begin
      hot_row[i] = ROW_W'($urandom_range(0, (1 << ROW_W) - 1));
      hot_col[i] = COL_W'($urandom_range(0, (1 << COL_W) - 1));
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_register_access();
    test_directed();
    test_random_settings(RST_LOW_LIMIT, RST_HIGH_LIMIT, RST_SAMPLING_PERIOD,
                         RST_LEARNING_LENGTH, 90, 1'b1, 1'b0);
    test_random_settings(8'd0, 8'd0, 8'd1, 16'd0, 40, 1'b1, 1'b0);
    test_random_settings(8'd255, 8'd255, 8'd255, 16'hFFFF, 40, 1'b1, 1'b0);
    test_random_settings(CH_W'($urandom_range(1, 60)), CH_W'($urandom_range(60, 200)), 8'd0,
                         LEARN_W'($urandom_range(0, 65535)), 40, 1'b1, 1'b0);
    test_random_settings(CH_W'($urandom_range(5, 40)), CH_W'($urandom_range(40, 120)), 8'd2,
                         16'd1000, 120, 1'b0, 1'b1);
    test_random_settings(CH_W'($urandom_range(0, 255)), CH_W'($urandom_range(0, 255)),
                         CH_W'($urandom_range(1, 255)), LEARN_W'($urandom_range(0, 65535)),
                         95, 1'b1, 1'b1);
    drain_results(2 * LATENCY_GUARD);
    $display("Covered %0d load, %0d subtract, %0d update and %0d unused-mode pixels; %0d flag pairs checked.",
             mode_count[MODE_LOAD], mode_count[MODE_SUBTRACT], mode_count[MODE_UPDATE],
             mode_count[MODE_UNUSED], results_checked);
    $display("Ran %0d limit settings over %0d register writes, zero and full scale included.",
             settings_run, reg_writes);
    if (error_count == 0) begin
      $display("** approx_median_background_subtract: PASSED **");
    end else begin
      $display("** approx_median_background_subtract: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/ambs_pkg.sv
hdl/ambs_regs.sv
hdl/ambs_rem.sv
hdl/ambs_lane.sv
hdl/approx_median_background_subtract.sv
tb/sv/approx_median_background_subtract_tb.sv
